### hw/rtl/grid_astar_path_search_macros.svh
// ----------------------------------------------------------------------------
// grid path search assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds whenever the antecedent holds
`define GASP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid path search assertion failed");
// property holds on every clock edge out of reset
`define GASP_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("grid path search assertion failed");
`else
`define GASP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define GASP_ASSERT_ALWAYS(label, clk, rst, expr)
`endif
`endif

### hw/rtl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// grid path search package
// shared constants, codes, state type and helper functions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gasp_pkg;
   localparam int GRID_SIDE  = 16;
   localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
   localparam int CELL_W     = 8;
   localparam int COST_W     = 8;
   localparam int G_W        = 17;
   localparam int PRIO_W     = 40;
   localparam int QENT_W     = PRIO_W + CELL_W;
   localparam int PITCH_W    = 16;
   localparam int DIM_W      = 5;
   localparam int SPAN_W     = 13;
   localparam int HEUR_W     = PITCH_W + SPAN_W - 8;
   localparam int TRAIL_W    = 9;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      STATUS_PATH     = 2'd0,
      STATUS_UNREACH  = 2'd1,
      STATUS_TRUNC    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_PITCH   = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_POP_CHECK, S_SCAN, S_MOVE_RD, S_MOVE_WR, S_EXP_RD, S_EXP_SUM,
      S_NB_CHECK, S_NB_CMP, S_NB_PUSH, S_TR_STEP, S_TR_WAIT, S_EM_RD,
      S_EM_LOAD, S_RSP_WAIT
   } state_type;

   typedef struct packed {
      logic signed [1:0] dr;
      logic signed [1:0] dc;
   } step_type;

   typedef struct packed {
      logic                start;
      logic [CELL_W-1:0]   node;
      logic [CELL_W-1:0]   goal;
      logic [PITCH_W-1:0]  pitch;
   } heur_req_type;

   // neighbour order n, e, s, w, nw, ne, se, sw
   function automatic step_type nb_step(input logic [2:0] d);
      step_type s;
      case (d)
         3'd0:    s = '{dr: -2'sd1, dc:  2'sd0};
         3'd1:    s = '{dr:  2'sd0, dc:  2'sd1};
         3'd2:    s = '{dr:  2'sd1, dc:  2'sd0};
         3'd3:    s = '{dr:  2'sd0, dc: -2'sd1};
         3'd4:    s = '{dr: -2'sd1, dc: -2'sd1};
         3'd5:    s = '{dr: -2'sd1, dc:  2'sd1};
         3'd6:    s = '{dr:  2'sd1, dc:  2'sd1};
         default: s = '{dr:  2'sd1, dc: -2'sd1};
      endcase
      return s;
   endfunction

   // active dimension clamped to 1..grid side
   function automatic logic [DIM_W-1:0] active_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(GRID_SIDE)) r = DIM_W'(GRID_SIDE);
      else r = v;
      return r;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid path search
// a* search over an eight-connected cost grid with path read-out
// ----------------------------------------------------------------------------
// channel   direction  signals
// req       in         req_valid/req_ready, operation, cell, cost, goal
// rsp       out        rsp_valid/rsp_ready, path_cell, status, last
// csr       in         csr_wr_en, csr_index, csr_wr_data
//
// a cost write is taken in S_IDLE; req_ready stays high afterwards
// a search repeats a queue scan, pop and cost fetch for each popped cell,
// then checks each neighbour in turn: off-grid, skipped or pushed
// path read-out walks came_from back from the goal, then emits the trail as results
// reset is synchronous and clears control state only, no clearing pass
// a stalled rsp holds the sequencer; no transaction is taken until done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_astar_path_search_macros.svh"
module grid_astar_path_search
   import gasp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2048,
   parameter int MAX_PATH    = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_operation,
   input  wire logic [CELL_W-1:0]    req_cell_index,
   input  wire logic [COST_W-1:0]    req_cell_cost,
   input  wire logic [CELL_W-1:0]    req_goal_cell,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [CELL_W-1:0]         rsp_path_cell,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PITCH_W-1:0]   csr_wr_data
);
   localparam int QA_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int KW    = $clog2(MAX_PATH);
   localparam int CA_W  = $clog2(CELL_TOTAL);

   state_type            state_ff, state_in;
   logic [DIM_W-1:0]     cols_ff, rows_ff, cols, rows;
   logic [PITCH_W-1:0]   pitch_ff;
   logic [CELL_W-1:0]    start_ff, goal_ff, cur_ff, nb_ff, cell_ff;
   logic [CNT_W-1:0]     count_ff, scan_issue_ff;
   logic                 scan_pend_ff, best_have_ff;
   logic [QA_W-1:0]      pend_idx_ff, best_idx_ff;
   logic [PRIO_W-1:0]    best_prio_ff;
   logic [CELL_W-1:0]    best_cell_ff;
   logic [G_W-1:0]       fresh_ff;
   logic [2:0]           dir_ff;
   logic [CELL_TOTAL-1:0] known_ff;
   logic [TRAIL_W-1:0]   trail_n_ff;
   logic                 long_ff;
   logic [KW-1:0]        emit_k_ff;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   status_type           rsp_status_ff;

   // combinational helpers
   logic                 req_acc, search_ok, scan_issue, better, skip, in_grid;
   logic signed [5:0]    nr, nc;
   logic [CELL_W-1:0]    nb;
   step_type             st;
   logic [PRIO_W-1:0]    q_prio;
   logic [CELL_W-1:0]    q_cell;
   logic [TRAIL_W-1:0]   n_new, em_addr;
   logic [HEUR_W-1:0]    heur;
   heur_req_type         heur_req;

   // ram ports
   logic                 cost_we, best_we, came_we, q_we, tr_we;
   logic [CA_W-1:0]      cost_wa, cost_ra, best_wa, best_ra, came_wa, came_ra;
   logic [CA_W-1:0]      tr_wa, tr_ra;
   logic [COST_W-1:0]    cost_rd;
   logic [G_W-1:0]       best_wd, best_rd;
   logic [CELL_W-1:0]    came_wd, came_rd, tr_rd;
   logic [QA_W-1:0]      q_wa, q_ra;
   logic [QENT_W-1:0]    q_wd, q_rd;

   assign cols    = active_dim(cols_ff);
   assign rows    = active_dim(rows_ff);
   assign req_acc = req_valid && req_ready;
   assign search_ok = ({1'b0, req_cell_index[3:0]} < cols)
                   && ({1'b0, req_cell_index[7:4]} < rows)
                   && ({1'b0, req_goal_cell[3:0]} < cols)
                   && ({1'b0, req_goal_cell[7:4]} < rows);

   // queue scan compare
   assign q_prio     = q_rd[QENT_W-1:CELL_W];
   assign q_cell     = q_rd[CELL_W-1:0];
   assign scan_issue = scan_issue_ff < count_ff;
   assign better     = !best_have_ff || (q_prio < best_prio_ff)
                    || ((q_prio == best_prio_ff) && (q_cell < best_cell_ff));

   // neighbour address
   always_comb begin
      st = nb_step(dir_ff);
      nr = $signed({2'b00, cur_ff[7:4]}) + 6'(st.dr);
      nc = $signed({2'b00, cur_ff[3:0]}) + 6'(st.dc);
      in_grid = !nr[5] && !nc[5] && (nr[4:0] < rows) && (nc[4:0] < cols);
      nb = {nr[3:0], nc[3:0]};
   end

   assign skip    = known_ff[nb_ff] && (fresh_ff >= best_rd);
   assign n_new   = trail_n_ff + TRAIL_W'(1);
   assign em_addr = trail_n_ff - TRAIL_W'(1) - TRAIL_W'(emit_k_ff);

   assign heur_req = '{start: (state_ff == S_NB_CHECK), node: nb, goal: goal_ff,
                       pitch: pitch_ff};

   gasp_heur u_heur (
      .clock (clock),
      .req   (heur_req),
      .heur  (heur)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_operation == OP_SEARCH)) begin
               state_in = search_ok ? S_POP_CHECK : S_RSP_WAIT;
            end
         end
         S_POP_CHECK: state_in = (count_ff == '0) ? S_RSP_WAIT : S_SCAN;
         S_SCAN:      if (!scan_issue && !scan_pend_ff) state_in = S_MOVE_RD;
         S_MOVE_RD:   state_in = S_MOVE_WR;
         S_MOVE_WR:   state_in = (best_cell_ff == goal_ff) ? S_TR_STEP : S_EXP_RD;
         S_EXP_RD:    state_in = S_EXP_SUM;
         S_EXP_SUM:   state_in = S_NB_CHECK;
         S_NB_CHECK: begin
            if (in_grid) state_in = S_NB_CMP;
            else if (dir_ff == 3'd7) state_in = S_POP_CHECK;
         end
         S_NB_CMP: begin
            if (skip) state_in = (dir_ff == 3'd7) ? S_POP_CHECK : S_NB_CHECK;
            else if (count_ff >= CNT_W'(QUEUE_DEPTH)) state_in = S_RSP_WAIT;
            else state_in = S_NB_PUSH;
         end
         S_NB_PUSH: state_in = (dir_ff == 3'd7) ? S_POP_CHECK : S_NB_CHECK;
         S_TR_STEP: begin
            if ((cell_ff == start_ff) || n_new[TRAIL_W-1]) state_in = S_EM_RD;
            else state_in = S_TR_WAIT;
         end
         S_TR_WAIT: state_in = S_TR_STEP;
         S_EM_RD: begin
            if (long_ff && (emit_k_ff == KW'(MAX_PATH - 1))) state_in = S_RSP_WAIT;
            else state_in = S_EM_LOAD;
         end
         S_EM_LOAD: state_in = S_RSP_WAIT;
         S_RSP_WAIT: begin
            if (rsp_ready) state_in = rsp_last_ff ? S_IDLE : S_EM_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and ram controls
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      cost_we = 1'b0; cost_wa = req_cell_index; cost_ra = cur_ff;
      best_we = 1'b0; best_wa = nb_ff; best_wd = fresh_ff; best_ra = cur_ff;
      came_we = 1'b0; came_wa = nb_ff; came_wd = cur_ff; came_ra = cell_ff;
      q_we = 1'b0; q_wa = count_ff[QA_W-1:0];
      q_wd = {fresh_ff, 8'b0} + PRIO_W'(heur);
      q_wd = {q_wd[PRIO_W-1:0], nb_ff};
      q_ra = scan_issue_ff[QA_W-1:0];
      tr_we = 1'b0; tr_wa = trail_n_ff[CA_W-1:0]; tr_ra = em_addr[CA_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_operation == OP_WRITE)) cost_we = 1'b1;
            if (req_acc && (req_operation == OP_SEARCH) && search_ok) begin
               best_we = 1'b1; best_wa = req_cell_index; best_wd = '0;
               came_we = 1'b1; came_wa = req_cell_index; came_wd = req_cell_index;
               q_we = 1'b1; q_wa = '0; q_wd = {PRIO_W'(0), req_cell_index};
            end
         end
         S_MOVE_RD:  q_ra = QA_W'(count_ff - CNT_W'(1));
         S_MOVE_WR: begin
            q_we = 1'b1; q_wa = best_idx_ff; q_wd = q_rd;
         end
         S_NB_CHECK: best_ra = nb;
         S_NB_PUSH: begin
            best_we = 1'b1; came_we = 1'b1; q_we = 1'b1;
         end
         S_TR_STEP:  tr_we = 1'b1;
         default: ;
      endcase
   end

   gasp_ram #(.WIDTH(COST_W), .DEPTH(CELL_TOTAL)) u_cost (
      .clock(clock), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(req_cell_cost),
      .rd_addr(cost_ra), .rd_data(cost_rd));
   gasp_ram #(.WIDTH(G_W), .DEPTH(CELL_TOTAL)) u_best (
      .clock(clock), .wr_en(best_we), .wr_addr(best_wa), .wr_data(best_wd),
      .rd_addr(best_ra), .rd_data(best_rd));
   gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELL_TOTAL)) u_came (
      .clock(clock), .wr_en(came_we), .wr_addr(came_wa), .wr_data(came_wd),
      .rd_addr(came_ra), .rd_data(came_rd));
   gasp_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));
   gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELL_TOTAL)) u_trail (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(cell_ff),
      .rd_addr(tr_ra), .rd_data(tr_rd));

   // state register and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= DIM_W'(GRID_SIDE);
         rows_ff      <= DIM_W'(GRID_SIDE);
         pitch_ff     <= PITCH_W'(256);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         known_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLUMNS: cols_ff  <= csr_wr_data[DIM_W-1:0];
               CSR_ROWS:    rows_ff  <= csr_wr_data[DIM_W-1:0];
               CSR_PITCH:   pitch_ff <= csr_wr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc && (req_operation == OP_SEARCH)) begin
                  if (search_ok) begin
                     count_ff <= CNT_W'(1);
                     known_ff <= CELL_TOTAL'(1) << req_cell_index;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_POP_CHECK: if (count_ff == '0) rsp_valid_ff <= 1'b1;
            S_MOVE_RD:   count_ff <= count_ff - CNT_W'(1);
            S_NB_CMP: begin
               if (!skip && (count_ff >= CNT_W'(QUEUE_DEPTH))) rsp_valid_ff <= 1'b1;
            end
            S_NB_PUSH: begin
               count_ff <= count_ff + CNT_W'(1);
               known_ff[nb_ff] <= 1'b1;
            end
            S_EM_RD: begin
               if (long_ff && (emit_k_ff == KW'(MAX_PATH - 1))) rsp_valid_ff <= 1'b1;
            end
            S_EM_LOAD:  rsp_valid_ff <= 1'b1;
            S_RSP_WAIT: if (rsp_ready) rsp_valid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // search datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            start_ff      <= req_cell_index;
            goal_ff       <= req_goal_cell;
            rsp_cell_ff   <= '0;
            rsp_status_ff <= STATUS_UNREACH;
            rsp_last_ff   <= 1'b1;
         end
         S_POP_CHECK: begin
            scan_issue_ff <= '0;
            scan_pend_ff  <= 1'b0;
            best_have_ff  <= 1'b0;
            rsp_cell_ff   <= '0;
            rsp_status_ff <= STATUS_UNREACH;
            rsp_last_ff   <= 1'b1;
         end
         S_SCAN: begin
            if (scan_issue) scan_issue_ff <= scan_issue_ff + CNT_W'(1);
            scan_pend_ff <= scan_issue;
            pend_idx_ff  <= scan_issue_ff[QA_W-1:0];
            if (scan_pend_ff) begin
               best_have_ff <= 1'b1;
               if (better) begin
                  best_prio_ff <= q_prio;
                  best_cell_ff <= q_cell;
                  best_idx_ff  <= pend_idx_ff;
               end
            end
         end
         S_MOVE_WR: begin
            cur_ff     <= best_cell_ff;
            cell_ff    <= goal_ff;
            trail_n_ff <= '0;
         end
         S_EXP_SUM: begin
            fresh_ff <= best_rd + G_W'(cost_rd);
            dir_ff   <= '0;
         end
         S_NB_CHECK: begin
            nb_ff <= nb;
            if (!in_grid) dir_ff <= dir_ff + 3'd1;
         end
         S_NB_CMP: begin
            if (skip) dir_ff <= dir_ff + 3'd1;
            rsp_cell_ff   <= '0;
            rsp_status_ff <= STATUS_OVERFLOW;
            rsp_last_ff   <= 1'b1;
         end
         S_NB_PUSH: dir_ff <= dir_ff + 3'd1;
         S_TR_STEP: begin
            trail_n_ff <= n_new;
            emit_k_ff  <= '0;
            if (cell_ff == start_ff) long_ff <= n_new > TRAIL_W'(MAX_PATH);
            else long_ff <= 1'b1;
         end
         S_TR_WAIT: cell_ff <= came_rd;
         S_EM_RD: begin
            rsp_cell_ff   <= '0;
            rsp_status_ff <= STATUS_TRUNC;
            rsp_last_ff   <= 1'b1;
         end
         S_EM_LOAD: begin
            rsp_cell_ff   <= tr_rd;
            rsp_status_ff <= STATUS_PATH;
            rsp_last_ff   <= !long_ff && ((TRAIL_W'(emit_k_ff) + TRAIL_W'(1)) == trail_n_ff);
         end
         S_RSP_WAIT: if (rsp_ready && !rsp_last_ff) emit_k_ff <= emit_k_ff + KW'(1);
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_cell = rsp_cell_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   `GASP_ASSERT_IMPLIES(a_idle_no_rsp, clock, reset, req_ready, !rsp_valid)
   `GASP_ASSERT_IMPLIES(a_fault_last, clock, reset,
      rsp_valid && (rsp_status != STATUS_PATH), rsp_last && (rsp_path_cell == '0))
   `GASP_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
endmodule
`default_nettype wire

### hw/rtl/gasp_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/gasp_heur.sv
// ----------------------------------------------------------------------------
// diagonal heuristic unit
// pitch * (256*(dx+dy) - 150*min(dx,dy)) / 256, one registered multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gasp_heur
   import gasp_pkg::*;
(
   input  wire logic         clock,
   input  heur_req_type      req,
   output logic [HEUR_W-1:0] heur
);
   logic [3:0]                dx;
   logic [3:0]                dy;
   logic [3:0]                mn;
   logic [SPAN_W-1:0]         span;
   logic [PITCH_W+SPAN_W-1:0] prod;
   logic [HEUR_W-1:0]         heur_ff;
   logic [HEUR_W-1:0]         heur_in;

   // column and row distances, diagonal span and scaled product
   always_comb begin
      dx = (req.node[3:0] > req.goal[3:0]) ? req.node[3:0] - req.goal[3:0]
                                            : req.goal[3:0] - req.node[3:0];
      dy = (req.node[7:4] > req.goal[7:4]) ? req.node[7:4] - req.goal[7:4]
                                            : req.goal[7:4] - req.node[7:4];
      mn = (dx < dy) ? dx : dy;
      span = {({1'b0, dx} + {1'b0, dy}), 8'b0} - SPAN_W'(mn) * SPAN_W'(150);
      prod = PITCH_W'(req.pitch) * SPAN_W'(span);
      heur_in = req.start ? prod[PITCH_W+SPAN_W-1:8] : heur_ff;
   end

   always_ff @(posedge clock) begin
      heur_ff <= heur_in;
   end

   assign heur = heur_ff;
endmodule
`default_nettype wire
